>>> rtl/core/mana_pkg.sv
// Package for the moving average neighbour alert block.
// Holds window sizing, divider constants, register addresses and shared types.
// No dependencies.
`default_nettype none

package mana_pkg;

  // Window and sample sizing
  localparam int WINDOW      = 10;
  localparam int SAMPLE_BITS = 16;
  localparam int SLOT_W      = $clog2(WINDOW);
  localparam int SUM_W       = SAMPLE_BITS + $clog2(WINDOW);

  // Divide by WINDOW as multiply by reciprocal; error stays below one LSB
  localparam int DIV_SHIFT = SUM_W + $clog2(WINDOW);
  localparam int MULT_W    = DIV_SHIFT - $clog2(WINDOW) + 2;
  localparam logic [MULT_W-1:0] DIV_MULT =
    MULT_W'(((64'd1 << DIV_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));
  localparam int PROD_W = SUM_W + MULT_W;

  // Alert needs at least this many matching neighbours
  localparam logic [2:0] MIN_MATCHES = 3'd2;

  // Stream packing
  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 24;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam logic REG_ALERT_THRESHOLD = 1'b0;
  localparam logic REG_MATCH_TOLERANCE = 1'b1;

  // Neighbour averages and presence bits travel together
  typedef struct packed {
    logic [3:0]             present;
    logic [SAMPLE_BITS-1:0] east;
    logic [SAMPLE_BITS-1:0] west;
    logic [SAMPLE_BITS-1:0] south;
    logic [SAMPLE_BITS-1:0] north;
  } mana_nbr_t;

endpackage

`default_nettype wire

>>> rtl/core/moving_average_neighbour_alert_top.sv
// Top level of the moving average neighbour alert block.
// Instantiates mana_window; divides the sum, compares neighbours, registers the result.
// Depends on mana_pkg and mana_window.
`default_nettype none

// The block takes one word per clock cycle, unless the result stream stalls, and returns
// one result word for each. Ring read, sum update and reciprocal multiply each take a
// register stage, and the neighbour compare feeds the output register. The ten-entry
// sample ring is read and written back once per word, which sets the one-word-per-cycle
// rate.
// Unwritten ring entries read as zero, so the average ramps up after reset.
// Write alert_threshold at byte address 0 and match_tolerance at address 4
// only while no words are in flight.
module moving_average_neighbour_alert_top (
  input  logic                              clk,
  input  logic                              rst_n,
  // sample[15:0], north_avg[31:16], south_avg[47:32], west_avg[63:48],
  // east_avg[79:64], present_mask[83:80], zero[87:84]
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [mana_pkg::IN_DATA_W-1:0]    in_tdata,
  // average[15:0], match_count[18:16], alert[19], zero[23:20]
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [mana_pkg::OUT_DATA_W-1:0]   out_tdata,
  // Configuration port
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [mana_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [31:0]                       cfg_pwdata,
  output logic [31:0]                       cfg_prdata,
  output logic                              cfg_pready
);
  import mana_pkg::*;

  logic [SAMPLE_BITS-1:0] thr_r;
  logic [SAMPLE_BITS-1:0] tol_r;
  logic                   cfg_wr;

  mana_nbr_t              in_nbr;
  logic                   sum_valid;
  logic                   sum_ready;
  logic [SUM_W-1:0]       sum_value;
  mana_nbr_t              sum_nbr;

  logic                   av_v_r;
  logic [SAMPLE_BITS-1:0] avg_r;
  mana_nbr_t              av_nbr_r;
  logic [PROD_W-1:0]      prod;

  logic                   out_v_r;
  logic [OUT_DATA_W-1:0]  out_data_r;
  logic                   en_out;
  logic                   en_av;

  logic [3:0]             match;
  logic [2:0]             match_cnt;
  logic                   alert;
  logic [SAMPLE_BITS-1:0] nb [4];
  logic [SAMPLE_BITS-1:0] diff [4];

  // Configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '1;
      tol_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_ALERT_THRESHOLD: thr_r <= cfg_pwdata[SAMPLE_BITS-1:0];
        REG_MATCH_TOLERANCE: tol_r <= cfg_pwdata[SAMPLE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_ALERT_THRESHOLD: cfg_prdata = 32'(thr_r);
      REG_MATCH_TOLERANCE: cfg_prdata = 32'(tol_r);
      default:             cfg_prdata = '0;
    endcase
  end

  // Unpack the input word
  assign in_nbr.north   = in_tdata[31:16];
  assign in_nbr.south   = in_tdata[47:32];
  assign in_nbr.west    = in_tdata[63:48];
  assign in_nbr.east    = in_tdata[79:64];
  assign in_nbr.present = in_tdata[83:80];

  mana_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_sample (in_tdata[SAMPLE_BITS-1:0]),
    .in_nbr    (in_nbr),
    .sum_valid (sum_valid),
    .sum_ready (sum_ready),
    .sum_value (sum_value),
    .sum_nbr   (sum_nbr)
  );

  assign en_out    = !out_v_r || out_tready;
  assign en_av     = !av_v_r || en_out;
  assign sum_ready = en_av;

  // Divide the sum by the window length through the reciprocal
  assign prod = PROD_W'(sum_value) * PROD_W'(DIV_MULT);

  always_ff @(posedge clk) begin
    if (sum_valid && en_av) begin
      avg_r    <= prod[DIV_SHIFT +: SAMPLE_BITS];
      av_nbr_r <= sum_nbr;
    end
  end

  // Compare each present neighbour with the average
  assign nb[0] = av_nbr_r.north;
  assign nb[1] = av_nbr_r.south;
  assign nb[2] = av_nbr_r.west;
  assign nb[3] = av_nbr_r.east;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      diff[k]  = (avg_r >= nb[k]) ? (avg_r - nb[k]) : (nb[k] - avg_r);
      match[k] = av_nbr_r.present[k] && (diff[k] <= tol_r);
    end
  end

  assign match_cnt = 3'(match[0]) + 3'(match[1]) + 3'(match[2]) + 3'(match[3]);
  assign alert     = (avg_r >= thr_r) && (match_cnt >= MIN_MATCHES);

  // Hold the result word until taken
  always_ff @(posedge clk) begin
    if (av_v_r && en_out) begin
      out_data_r <= {4'b0, alert, match_cnt, avg_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      av_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (en_av) begin
        av_v_r <= sum_valid;
      end
      if (en_out) begin
        out_v_r <= av_v_r;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

>>> rtl/core/mana_window.sv
// Sample ring and running sum for the moving average neighbour alert block.
// Reads the oldest entry, updates the sum, writes the new sample back.
// Depends on mana_pkg.
`default_nettype none

module mana_window (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [mana_pkg::SAMPLE_BITS-1:0] in_sample,
  input  mana_pkg::mana_nbr_t             in_nbr,
  output logic                            sum_valid,
  input  logic                            sum_ready,
  output logic [mana_pkg::SUM_W-1:0]      sum_value,
  output mana_pkg::mana_nbr_t             sum_nbr
);
  import mana_pkg::*;

  // Ring storage; entries without a valid bit read as zero
  logic [SAMPLE_BITS-1:0] ring_mem [WINDOW];
  logic [WINDOW-1:0]      ent_valid_r;

  logic [SLOT_W-1:0]      slot_r;
  logic [SLOT_W-1:0]      slot_nxt;

  // Read stage
  logic                   rd_v_r;
  logic [SLOT_W-1:0]      rd_slot_r;
  logic [SAMPLE_BITS-1:0] rd_sample_r;
  mana_nbr_t              rd_nbr_r;
  logic [SAMPLE_BITS-1:0] rd_data_r;
  logic                   rd_hit_r;

  // Sum stage
  logic                   sv_r;
  logic [SUM_W-1:0]       sum_r;
  logic [SUM_W-1:0]       sum_nxt;
  mana_nbr_t              sum_nbr_r;

  logic                   en_sum;
  logic                   en_rd;
  logic                   accept;
  logic                   commit;
  logic [SAMPLE_BITS-1:0] old_sample;

  assign en_sum   = !sv_r || sum_ready;
  assign en_rd    = !rd_v_r || en_sum;
  assign in_ready = en_rd;
  assign accept   = in_valid && en_rd;
  assign commit   = rd_v_r && en_sum;

  // Advance write slot with wrap
  always_comb begin
    if (slot_r == SLOT_W'(WINDOW - 1)) begin
      slot_nxt = '0;
    end else begin
      slot_nxt = slot_r + SLOT_W'(1);
    end
  end

  // Drop the oldest entry, add the new word
  assign old_sample = rd_hit_r ? rd_data_r : '0;
  assign sum_nxt    = sum_r - SUM_W'(old_sample) + SUM_W'(rd_sample_r);

  // Ring memory: read on accept, write back on commit
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data_r <= ring_mem[slot_r];
    end
    if (commit) begin
      ring_mem[rd_slot_r] <= rd_sample_r;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r      <= '0;
      ent_valid_r <= '0;
      rd_v_r      <= 1'b0;
      sv_r        <= 1'b0;
      sum_r       <= '0;
    end else begin
      if (accept) begin
        slot_r <= slot_nxt;
      end
      if (en_rd) begin
        rd_v_r <= in_valid;
      end
      if (en_sum) begin
        sv_r <= rd_v_r;
      end
      if (commit) begin
        sum_r                  <= sum_nxt;
        ent_valid_r[rd_slot_r] <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_slot_r   <= slot_r;
      rd_sample_r <= in_sample;
      rd_nbr_r    <= in_nbr;
      rd_hit_r    <= ent_valid_r[slot_r];
    end
    if (commit) begin
      sum_nbr_r <= rd_nbr_r;
    end
  end

  assign sum_valid = sv_r;
  assign sum_value = sum_r;
  assign sum_nbr   = sum_nbr_r;

endmodule

`default_nettype wire

>>> rtl/core/mana_checker.sv
// Port-level checker for the moving average neighbour alert block.
// Watches the result stream only; bound to the top level below.
// Depends on mana_pkg.
`default_nettype none

module mana_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [mana_pkg::OUT_DATA_W-1:0] out_tdata
);
  import mana_pkg::*;

  // Stalled result word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word withdrawn while stalled");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result word offered right after reset");

  // At most four neighbours can match
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[18:16] <= 3'd4)
    else $error("match count above four");

  // Alert needs enough matching neighbours
  a_alert_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[19] |-> out_tdata[18:16] >= MIN_MATCHES)
    else $error("alert raised with too few matches");

endmodule

bind moving_average_neighbour_alert_top mana_checker u_mana_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

>>> bench/moving_average_neighbour_alert_top_tb.sv
// Self-checking testbench for moving_average_neighbour_alert_top: directed table, then random
// phases under several register settings, each result checked against a window predictor or a table row.
// Depends on mana_pkg and the RTL of the block.
`default_nettype none

module moving_average_neighbour_alert_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mana_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_WORDS = 115;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AFTER  = 400;

  // Result word layout, lowest bit first: average, match count, alert
  typedef struct packed {
    logic       alert;
    logic [2:0] count;
    logic [15:0] average;
  } alert_result_t;

  typedef struct packed {
    logic [15:0]   sample;
    mana_nbr_t     nbr;
    logic          typed;
    alert_result_t exp;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  // Predictor state: sample window, its sum, the next slot to overwrite, register copies
  logic [15:0] sample_ring [WINDOW];
  logic [SUM_W-1:0] ring_sum;
  int next_slot;
  logic [15:0] threshold_reg;
  logic [15:0] tolerance_reg;

  alert_result_t pending_results [$];
  stim_row_t directed_rows [$];

  int n_errors = 0;
  int in_accepted = 0;
  int cycles = 0;
  int tx_gap_pct = 0;
  int rx_stall_pct = 0;
  int stall_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  moving_average_neighbour_alert_top u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [15:0] clamp16(input int v);
    if (v < 0) return 16'h0000;
    if (v > 65535) return 16'hFFFF;
    return 16'(v);
  endfunction

  // Average the window would show if smp were accepted next
  function automatic int upcoming_average(input logic [15:0] smp);
    return (int'(ring_sum) - int'(sample_ring[next_slot]) + int'(smp)) / WINDOW;
  endfunction

  // Push one sample through the window and score the neighbours against the new average
  function automatic alert_result_t advance_window(input logic [15:0] smp, input mana_nbr_t nb);
    alert_result_t res;
    logic [15:0] nbr_avg [4];
    int diff;
    ring_sum = ring_sum - SUM_W'(sample_ring[next_slot]) + SUM_W'(smp);
    sample_ring[next_slot] = smp;
    next_slot = (next_slot == WINDOW - 1) ? 0 : next_slot + 1;
    res.average = 16'(ring_sum / WINDOW);
    res.count = 3'd0;
    nbr_avg[0] = nb.north;
    nbr_avg[1] = nb.south;
    nbr_avg[2] = nb.west;
    nbr_avg[3] = nb.east;
    for (int k = 0; k < 4; k++) begin
      // absent neighbours never match
      if (nb.present[k]) begin
        diff = int'(res.average) - int'(nbr_avg[k]);
        if (diff < 0) diff = -diff;
        if (diff <= int'(tolerance_reg)) res.count = res.count + 3'd1;
      end
    end
    res.alert = (res.average >= threshold_reg) && (res.count >= MIN_MATCHES);
    return res;
  endfunction

  task automatic add_row(input logic [15:0] smp, input logic [15:0] n, input logic [15:0] s,
                         input logic [15:0] w, input logic [15:0] e, input logic [3:0] mask,
                         input logic typed, input logic [15:0] e_avg, input logic [2:0] e_cnt,
                         input logic e_alert);
    stim_row_t row;
    row.sample = smp;
    row.nbr.north = n;
    row.nbr.south = s;
    row.nbr.west = w;
    row.nbr.east = e;
    row.nbr.present = mask;
    row.typed = typed;
    row.exp.average = e_avg;
    row.exp.count = e_cnt;
    row.exp.alert = e_alert;
    directed_rows.push_back(row);
  endtask

  // Offer one word, record its expected result once accepted, then maybe idle
  task automatic send_word(input logic [15:0] smp, input mana_nbr_t nb, input logic typed,
                           input alert_result_t exp);
    alert_result_t pred;
    in_tvalid <= 1'b1;
    in_tdata <= {4'h0, nb, smp};
    do @(posedge clk); while (!in_tready);
    pred = advance_window(smp, nb);
    pending_results.push_back(typed ? exp : pred);
    in_accepted++;
    if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  // APB write followed by a read-back of the same register
  task automatic write_reg(input logic idx, input logic [15:0] val);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= {16'h0000, val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (idx == REG_ALERT_THRESHOLD) threshold_reg = val;
    else tolerance_reg = val;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata[15:0] !== val) begin
      n_errors++;
      $display("%0t register %0d read expected %h actual %h", $time, idx, val,
               cfg_prdata[15:0]);
    end
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Drain the block before touching registers
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Receiver: check each result word, then pick the next ready value
  always @(posedge clk) begin
    alert_result_t got;
    alert_result_t want;
    logic nxt;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[19:0];
      if (pending_results.size() == 0) begin
        n_errors++;
        $display("%0t result %h with nothing expected", $time, got);
      end else begin
        want = pending_results.pop_front();
        if (got.average !== want.average) begin
          n_errors++;
          $display("%0t average expected %h actual %h", $time, want.average, got.average);
        end
        if (got.count !== want.count) begin
          n_errors++;
          $display("%0t match_count expected %0d actual %0d", $time, want.count, got.count);
        end
        if (got.alert !== want.alert) begin
          n_errors++;
          $display("%0t alert expected %b actual %b", $time, want.alert, got.alert);
        end
      end
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      nxt = 1'b0;
    end else if (!hold_done && in_accepted >= HOLD_AFTER) begin
      // long hold-off so the block backs up into its input
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      nxt = 1'b0;
    end else if (stall_left > 0 && rx_stall_pct != 0) begin
      stall_left = stall_left - 1;
      nxt = 1'b0;
    end else if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct) begin
      stall_left = $urandom_range(0, 13);
      nxt = 1'b0;
    end else begin
      nxt = 1'b1;
    end
    out_tready <= nxt;
  end

  initial begin
    stim_row_t row;
    mana_nbr_t nb;
    logic [15:0] smp;
    logic [15:0] nv [4];
    logic [15:0] thr;
    logic [15:0] tol;
    int pavg;
    int v;

    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    for (int k = 0; k < WINDOW; k++) sample_ring[k] = 16'h0000;
    ring_sum = '0;
    next_slot = 0;
    threshold_reg = 16'hFFFF;
    tolerance_reg = 16'h0000;

    // Directed table at reset settings (threshold all ones, tolerance zero)
    add_row(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 4'hF, 1, 16'h0000, 3'd4, 0);
    // absent neighbours equal to the average still do not match
    add_row(16'hFFFF, 16'h1999, 16'h1999, 16'h1999, 16'h1999, 4'h0, 1, 16'h1999, 3'd0, 0);
    // matches are reported below the threshold, alert stays low
    add_row(16'hFFFF, 16'h3333, 16'h0000, 16'h3333, 16'hFFFF, 4'h5, 1, 16'h3333, 3'd2, 0);
    add_row(16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 4'hF, 0, 0, 0, 0);
    add_row(16'hFFFF, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 4'hA, 0, 0, 0, 0);
    add_row(16'hFFFF, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 4'h5, 0, 0, 0, 0);
    add_row(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'hF, 0, 0, 0, 0);
    add_row(16'hFFFF, 16'h8000, 16'h7FFF, 16'h0001, 16'hFFFE, 4'hF, 0, 0, 0, 0);
    add_row(16'hFFFF, 16'hCCCC, 16'hCCCC, 16'hCCCC, 16'hCCCC, 4'h9, 0, 0, 0, 0);
    add_row(16'hFFFF, 16'hE666, 16'hE666, 16'hE666, 16'hE666, 4'h6, 0, 0, 0, 0);
    // slot wraps; full window of all-ones gives the largest average
    add_row(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 4'h3, 1, 16'hFFFF, 3'd2, 1);
    add_row(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'h1, 1, 16'hFFFF, 3'd1, 0);
    add_row(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'hF, 1, 16'hFFFF, 3'd4, 1);
    add_row(16'h0000, 16'hE666, 16'hE665, 16'hFFFF, 16'h0000, 4'hF, 0, 0, 0, 0);
    add_row(16'hAAAA, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 4'hC, 0, 0, 0, 0);
    add_row(16'h5555, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 4'h3, 0, 0, 0, 0);
    add_row(16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h0001, 4'hF, 0, 0, 0, 0);
    add_row(16'h8000, 16'hC000, 16'hC000, 16'hC000, 16'hC000, 4'hF, 0, 0, 0, 0);
    add_row(16'h7FFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 4'hF, 0, 0, 0, 0);
    add_row(16'h0000, 16'h1234, 16'h4321, 16'h8765, 16'h5678, 4'hB, 0, 0, 0, 0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_gap_pct = 20;
    rx_stall_pct = 20;
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_word(row.sample, row.nbr, row.typed, row.exp);
    end

    // Random phases, each under its own register setting; last phase runs without idling
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin thr = 16'h0000; tol = 16'hFFFF; end
        1: begin thr = 16'h0000; tol = 16'h0000; end
        2: begin thr = 16'hFFFF; tol = 16'hFFFF; end
        default: begin
          thr = 16'($urandom_range(0, 65535));
          tol = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1024));
        end
      endcase
      wait_drained();
      write_reg(REG_ALERT_THRESHOLD, thr);
      write_reg(REG_MATCH_TOLERANCE, tol);
      if (ph == 7) begin
        tx_gap_pct = 0;
        rx_stall_pct = 0;
      end else begin
        tx_gap_pct = (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 15 : 40;
        rx_stall_pct = (ph % 3 == 2) ? 0 : (ph % 3 == 0) ? 35 : 10;
      end

      for (int i = 0; i < PHASE_WORDS; i++) begin
        // steer samples toward the threshold so the average crosses it often
        case ($urandom_range(0, 9))
          0: smp = 16'h0000;
          1: smp = 16'hFFFF;
          2, 3, 4, 5: smp = clamp16(int'(threshold_reg) + int'($urandom_range(0, 512)) - 256);
          default: smp = 16'($urandom);
        endcase
        // place neighbours on, just inside and just outside the tolerance band
        pavg = upcoming_average(smp);
        for (int k = 0; k < 4; k++) begin
          case ($urandom_range(0, 5))
            0: v = pavg;
            1: v = pavg + int'(tolerance_reg);
            2: v = pavg - int'(tolerance_reg);
            3: v = pavg + int'(tolerance_reg) + 1;
            4: v = pavg - int'(tolerance_reg) - 1;
            default: v = int'($urandom_range(0, 65535));
          endcase
          nv[k] = clamp16(v);
        end
        nb.north = nv[0];
        nb.south = nv[1];
        nb.west = nv[2];
        nb.east = nv[3];
        nb.present = ($urandom_range(0, 2) == 0) ? 4'hF : 4'($urandom);
        send_word(smp, nb, 1'b0, '0);
      end
    end

    // Drain and give stray words time to show up
    wait_drained();
    repeat (8) @(posedge clk);
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
